// ===== design/sfp_pkg.sv =====
package sfp_pkg;

    localparam int MAX_BURST    = 64;
    localparam int HEADER_BYTES = 8;
    localparam int MIN_PACKET   = 64;
    localparam int ALIGN_BYTES  = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam int BURST_CNT_W  = $clog2(MAX_BURST + 1);
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

    typedef enum logic [0:0] {
        CFG_FRAME_CAPACITY     = 1'b0,
        CFG_FRAME_PACKET_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [5:0]  frame_index;
        logic [16:0] payload_offset;
        logic [15:0] padded_length;
        logic [6:0]  pad_bytes;
        logic        upscaled;
    } desc_t;

    typedef struct packed {
        desc_t       desc;
        logic        has_next_header;
        logic [16:0] frame_bytes;
        logic [21:0] burst_total_bytes;
        logic        burst_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== design/sfp_result_queue.sv =====
module sfp_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  sfp_pkg::push_t  push,
    input  logic            pop,
    output logic            not_empty,
    output logic            room,
    output sfp_pkg::result_t head
);
    import sfp_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wptr_reg;
    logic [QUEUE_PTR_W-1:0] wptr_next;
    logic [QUEUE_PTR_W-1:0] rptr_reg;
    logic [QUEUE_PTR_W-1:0] rptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic [QUEUE_CNT_W-1:0] cnt_next;
    logic [QUEUE_PTR_W-1:0] second_ptr;

    assign not_empty  = (cnt_reg != '0);
    assign room       = (cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign head       = entry_reg[rptr_reg];
    assign second_ptr = wptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        wptr_next = wptr_reg + QUEUE_PTR_W'(push.count);
        rptr_next = pop ? rptr_reg + QUEUE_PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[second_ptr] <= push.second;
        end
    end

endmodule

// ===== design/super_frame_packer.sv =====
// A descriptor passes the input stage register, then the result queue, once the request that
// settles it (the next packet, or its own request on the last packet of a burst) is accepted.
// Throughput: one request per cycle while the result queue has room; a burst's first packet
// yields no descriptor unless it ends the burst, and a later end yields two, so while the
// output is ready the input never stalls. Reset clears the burst state and the result queue,
// and sets frame_capacity to 0 and frame_packet_limit to 1.
module super_frame_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] packet_length,
    input  logic        burst_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  frame_index,
    output logic [16:0] payload_offset,
    output logic [15:0] padded_length,
    output logic [6:0]  pad_bytes,
    output logic        upscaled,
    output logic        has_next_header,
    output logic [16:0] frame_bytes,
    output logic [21:0] burst_total_bytes,
    output logic        burst_end
);
    import sfp_pkg::*;

    logic                   stage_valid_reg;
    logic [15:0]            stage_length_reg;
    logic                   stage_last_reg;
    logic [15:0]            capacity_reg;
    logic [15:0]            limit_reg;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    desc_t                  pend_desc_reg;
    logic [16:0]            fill_reg;
    logic [16:0]            fill_next;
    logic [15:0]            count_reg;
    logic [15:0]            count_next;
    logic [5:0]             frame_reg;
    logic [5:0]             frame_next;
    logic [21:0]            bytes_reg;
    logic [21:0]            bytes_next;
    logic [BURST_CNT_W-1:0] packets_reg;
    logic [BURST_CNT_W-1:0] packets_next;

    logic                   fire;
    logic                   room;
    logic                   not_empty;
    result_t                head;
    push_t                  push;

    logic                   short_packet;
    logic [15:0]            padded;
    logic [16:0]            need;
    logic [17:0]            fill_sum;
    logic                   packing;
    logic                   join_frame;
    logic                   end_now;
    logic [22:0]            bytes_sum;
    desc_t                  cur;
    result_t                held_result;
    result_t                end_result;

    assign fire     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || fire;

    always_comb
    begin
        short_packet = (stage_length_reg < 16'(MIN_PACKET));
        padded       = short_packet ? 16'(MIN_PACKET) : stage_length_reg;
        need         = (17'(padded) + 17'(HEADER_BYTES + ALIGN_BYTES - 1))
                       & ~17'(ALIGN_BYTES - 1);
        fill_sum     = 18'(fill_reg) + 18'(need);
        packing      = (capacity_reg != 16'd0);
        join_frame   = pend_valid_reg && packing && (fill_sum <= 18'(capacity_reg))
                       && (count_reg < limit_reg);

        cur.padded_length = padded;
        cur.pad_bytes     = 7'(padded - stage_length_reg);
        cur.upscaled      = short_packet;

        if (join_frame)
        begin
            cur.payload_offset = fill_reg + 17'(HEADER_BYTES);
            fill_next          = fill_sum[16:0];
            count_next         = count_reg + 16'd1;
            frame_next         = frame_reg;
        end
        else
        begin
            cur.payload_offset = packing ? 17'(HEADER_BYTES) : 17'd0;
            fill_next          = packing ? need : 17'(padded);
            count_next         = 16'd1;
            frame_next         = pend_valid_reg ? frame_reg + 6'd1 : frame_reg;
        end
        cur.frame_index = frame_next;

        bytes_sum    = 23'(bytes_reg) + 23'(padded);
        bytes_next   = (bytes_sum > 23'(TOTAL_MAX)) ? TOTAL_MAX : bytes_sum[21:0];
        packets_next = packets_reg + BURST_CNT_W'(1);
        end_now      = stage_last_reg || (packets_next >= BURST_CNT_W'(MAX_BURST));

        held_result.desc              = pend_desc_reg;
        held_result.has_next_header   = join_frame;
        held_result.frame_bytes       = join_frame ? 17'd0 : fill_reg;
        held_result.burst_total_bytes = 22'd0;
        held_result.burst_end         = 1'b0;

        end_result.desc               = cur;
        end_result.has_next_header    = 1'b0;
        end_result.frame_bytes        = fill_next;
        end_result.burst_total_bytes  = bytes_next;
        end_result.burst_end          = 1'b1;

        push.first  = pend_valid_reg ? held_result : end_result;
        push.second = end_result;
        push.count  = fire ? 2'(pend_valid_reg) + 2'(end_now) : 2'd0;

        pend_valid_next = !end_now;
        if (end_now)
        begin
            fill_next    = 17'd0;
            count_next   = 16'd0;
            frame_next   = 6'd0;
            bytes_next   = 22'd0;
            packets_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            capacity_reg    <= 16'd0;
            limit_reg       <= 16'd1;
            pend_valid_reg  <= 1'b0;
            fill_reg        <= 17'd0;
            count_reg       <= 16'd0;
            frame_reg       <= 6'd0;
            bytes_reg       <= 22'd0;
            packets_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FRAME_CAPACITY:     capacity_reg <= cfg_data;
                    CFG_FRAME_PACKET_LIMIT: limit_reg    <= cfg_data;
                    default:                capacity_reg <= capacity_reg;
                endcase
            end
            if (fire)
            begin
                pend_valid_reg <= pend_valid_next;
                fill_reg       <= fill_next;
                count_reg      <= count_next;
                frame_reg      <= frame_next;
                bytes_reg      <= bytes_next;
                packets_reg    <= packets_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_length_reg <= packet_length;
            stage_last_reg   <= burst_last;
        end
        if (fire)
        begin
            pend_desc_reg <= cur;
        end
    end

    sfp_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && out_ready),
        .not_empty (not_empty),
        .room      (room),
        .head      (head)
    );

    assign out_valid         = not_empty;
    assign frame_index       = head.desc.frame_index;
    assign payload_offset    = head.desc.payload_offset;
    assign padded_length     = head.desc.padded_length;
    assign pad_bytes         = head.desc.pad_bytes;
    assign upscaled          = head.desc.upscaled;
    assign has_next_header   = head.has_next_header;
    assign frame_bytes       = head.frame_bytes;
    assign burst_total_bytes = head.burst_total_bytes;
    assign burst_end         = head.burst_end;

endmodule

// ===== design/sfp_checker.sv =====
module sfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] padded_length,
    input logic        has_next_header,
    input logic [16:0] frame_bytes,
    input logic [21:0] burst_total_bytes,
    input logic        burst_end
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("Output request dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_next_header == (frame_bytes == 17'd0)))
    else $error("Frame length must be given exactly when the frame closes.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && burst_end |-> !has_next_header)
    else $error("A burst end cannot be followed by another header.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !burst_end |-> (burst_total_bytes == 22'd0))
    else $error("Burst total reported outside a burst end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (padded_length >= 16'd64))
    else $error("Padded length below the minimum packet size.");

endmodule

bind super_frame_packer sfp_checker u_sfp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .padded_length     (padded_length),
    .has_next_header   (has_next_header),
    .frame_bytes       (frame_bytes),
    .burst_total_bytes (burst_total_bytes),
    .burst_end         (burst_end)
);
